// ===== hw/rtl/slmd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package slmd_pkg;

  localparam int unsigned CntW  = 16;
  localparam int unsigned DutyW = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CntW-1:0]  CntMax     = 16'hFFFF;
  localparam logic [DutyW-1:0] FadeStep   = 8'd5;
  localparam logic [DutyW-1:0] FadeTop    = 8'd250;
  localparam logic [DutyW-1:0] FadeBottom = 8'd5;
  localparam logic [DutyW-1:0] DutyFull   = 8'd255;

  localparam logic [CntW-1:0] UpdateIntervalRst = 16'd20;
  localparam logic [CntW-1:0] HeartbeatHalfRst  = 16'd500;
  localparam logic [CntW-1:0] ErrorHalfRst      = 16'd200;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_UPDATE_INTERVAL = 2'd0,
    CFG_HEARTBEAT_HALF  = 2'd1,
    CFG_ERROR_HALF      = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_BREATHE    = 2'd0,
    MODE_BLUE_BLINK = 2'd1,
    MODE_RED_BLINK  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    WIFI_WAITING = 2'd0,
    WIFI_CLIENT  = 2'd1,
    WIFI_FAULT   = 2'd2
  } wifi_e;

  typedef struct packed {
    logic [CntW-1:0] update_interval;
    logic [CntW-1:0] heartbeat_half_period;
    logic [CntW-1:0] error_half_period;
  } cfg_t;

  typedef struct packed {
    logic       link_fault;
    logic [1:0] wifi_state;
  } in_t;

  typedef struct packed {
    logic             updated;
    logic [1:0]       active_mode;
    logic             red_on;
    logic             blue_on;
    logic             blue_pwm_active;
    logic [DutyW-1:0] blue_duty;
  } out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/status_led_mode_driver_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Status LED mode driver. Each request is one millisecond tick carrying the
// engine-link error flag and the wireless state; each tick yields exactly one
// result with the LED state after that tick. Every update_interval ticks the
// mode is chosen by priority (error -> red blink, client connected -> blue
// blink, otherwise blue breathing PWM). A tick passes an input register,
// counter/compare logic and an output register: one request per cycle is
// sustained while the output is not stalled. Write the configuration
// registers only while no request is in flight.
module status_led_mode_driver_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [slmd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [slmd_pkg::CntW-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire slmd_pkg::in_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output slmd_pkg::out_t                     out_data_o
);
  import slmd_pkg::*;

  cfg_t cfg_q;
  logic in_valid_q;
  in_t  in_data_q;
  logic out_valid_q;
  out_t out_data_q;
  out_t result;
  logic out_free;
  logic step;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  slmd_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_data_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.update_interval       <= UpdateIntervalRst;
      cfg_q.heartbeat_half_period <= HeartbeatHalfRst;
      cfg_q.error_half_period     <= ErrorHalfRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_UPDATE_INTERVAL: cfg_q.update_interval       <= cfg_data_i;
        CFG_HEARTBEAT_HALF:  cfg_q.heartbeat_half_period <= cfg_data_i;
        CFG_ERROR_HALF:      cfg_q.error_half_period     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
    if (step) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/slmd_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module slmd_engine (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire slmd_pkg::in_t  item_i,
  input  wire slmd_pkg::cfg_t cfg_i,
  output slmd_pkg::out_t      result_o
);
  import slmd_pkg::*;

  mode_e            mode_q, mode_d;
  logic [CntW-1:0]  tsu_q, tsu_d;
  logic [CntW-1:0]  tst_q, tst_d;
  logic             blink_q, blink_d;
  logic [DutyW-1:0] fade_q, fade_d;
  logic             rising_q, rising_d;
  logic             pwm_q, pwm_d;
  logic             red_q, red_d;
  logic             blue_q, blue_d;
  logic             upd;

  always_comb begin
    mode_e           sel;
    logic [CntW-1:0] half;
    half     = '0;
    tsu_d    = (tsu_q == CntMax) ? tsu_q : tsu_q + 1'b1;
    tst_d    = (tst_q == CntMax) ? tst_q : tst_q + 1'b1;
    mode_d   = mode_q;
    blink_d  = blink_q;
    fade_d   = fade_q;
    rising_d = rising_q;
    pwm_d    = pwm_q;
    red_d    = red_q;
    blue_d   = blue_q;
    upd      = (tsu_d >= cfg_i.update_interval);

    if (item_i.link_fault || item_i.wifi_state == WIFI_FAULT) begin
      sel = MODE_RED_BLINK;
    end else if (item_i.wifi_state == WIFI_CLIENT) begin
      sel = MODE_BLUE_BLINK;
    end else begin
      sel = MODE_BREATHE;
    end

    if (upd) begin
      tsu_d = '0;
      if (sel != mode_q) begin
        mode_d = sel;
        tst_d  = '0;
        red_d  = 1'b0;
        blue_d = 1'b0;
        case (sel)
          MODE_BREATHE: begin
            fade_d   = '0;
            rising_d = 1'b1;
            pwm_d    = 1'b1;
          end
          MODE_BLUE_BLINK: begin
            pwm_d   = 1'b0;
            blink_d = 1'b1;
            blue_d  = 1'b1;
          end
          default: begin
            pwm_d   = 1'b0;
            blink_d = 1'b1;
            red_d   = 1'b1;
          end
        endcase
      end

      half = (mode_d == MODE_BLUE_BLINK) ? cfg_i.heartbeat_half_period
                                         : cfg_i.error_half_period;
      if (mode_d == MODE_BREATHE) begin
        if (rising_d) begin
          fade_d = (fade_d <= DutyFull - FadeStep) ? fade_d + FadeStep : DutyFull;
          if (fade_d >= FadeTop) begin
            rising_d = 1'b0;
          end
        end else if (fade_d <= FadeBottom) begin
          rising_d = 1'b1;
        end else begin
          fade_d = fade_d - FadeStep;
        end
      end else if (tst_d >= half) begin
        tst_d   = '0;
        blink_d = !blink_d;
        if (mode_d == MODE_BLUE_BLINK) begin
          blue_d = blink_d;
        end else begin
          red_d = blink_d;
        end
      end
    end
  end

  always_comb begin
    result_o.updated         = upd;
    result_o.active_mode     = mode_d;
    result_o.red_on          = red_d;
    result_o.blue_on         = blue_d;
    result_o.blue_pwm_active = pwm_d;
    result_o.blue_duty       = pwm_d ? DutyFull - fade_d : DutyFull;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_BREATHE;
      tsu_q    <= '0;
      tst_q    <= '0;
      blink_q  <= 1'b0;
      fade_q   <= '0;
      rising_q <= 1'b1;
      pwm_q    <= 1'b1;
      red_q    <= 1'b0;
      blue_q   <= 1'b0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      tsu_q    <= tsu_d;
      tst_q    <= tst_d;
      blink_q  <= blink_d;
      fade_q   <= fade_d;
      rising_q <= rising_d;
      pwm_q    <= pwm_d;
      red_q    <= red_d;
      blue_q   <= blue_d;
    end
  end

endmodule

`default_nettype wire
